[design/jsof_pkg.sv]
`default_nettype none

package jsof_pkg;

    localparam int unsigned SOF_DEPTH = 15;
    localparam int unsigned SOF_CNT_W = $clog2(SOF_DEPTH + 1);

    localparam logic [7:0] MARKER_PREFIX  = 8'hFF;
    localparam logic [7:0] CODE_SOI       = 8'hD8;
    localparam logic [7:0] CODE_SOF0      = 8'hC0;
    localparam logic [7:0] CODE_SOS       = 8'hDA;
    localparam logic [7:0] PRECISION_8BIT = 8'd8;
    localparam logic [7:0] SAMP_11        = 8'h11;
    localparam logic [7:0] SAMP_21        = 8'h21;
    localparam logic [7:0] SAMP_22        = 8'h22;
    localparam logic [7:0] COMP_ID_Y      = 8'd1;
    localparam logic [7:0] COMP_ID_CB     = 8'd2;
    localparam logic [7:0] COMP_ID_CR     = 8'd3;
    localparam logic [7:0] NCOMP_GRAY     = 8'd1;
    localparam logic [7:0] NCOMP_YUV      = 8'd3;
    localparam logic [7:0] QTAB_LUMA      = 8'd0;
    localparam logic [7:0] QTAB_CHROMA    = 8'd1;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SOI,
        PH_MARK,
        PH_CODE,
        PH_LENHI,
        PH_LENLO,
        PH_SOFPAY,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NOSOI,
        ST_MARKER,
        ST_FORMAT,
        ST_COMPS,
        ST_LONG
    } status_t;

    typedef enum logic [1:0] {
        FMT_GRAY,
        FMT_NV16,
        FMT_NV12
    } pix_fmt_t;

    typedef logic [SOF_DEPTH-1:0][7:0] sof_bytes_t;

    typedef struct packed {
        status_t  status;
        pix_fmt_t fmt;
    } sof_eval_t;

endpackage

`default_nettype wire

[design/jsof_sof_eval.sv]
`default_nettype none

module jsof_sof_eval
    import jsof_pkg::*;
(
    input  wire sof_bytes_t             sof_bytes,
    input  wire logic [SOF_CNT_W-1:0]   sof_count,
    output sof_eval_t                   result
);

    logic ids_ok;

    // three-component layout apart from the luma sampling byte
    assign ids_ok = (sof_bytes[6] == COMP_ID_Y) && (sof_bytes[8] == QTAB_LUMA)
                 && (sof_bytes[9] == COMP_ID_CB) && (sof_bytes[10] == SAMP_11)
                 && (sof_bytes[11] == QTAB_CHROMA) && (sof_bytes[12] == COMP_ID_CR)
                 && (sof_bytes[13] == SAMP_11) && (sof_bytes[14] == QTAB_CHROMA);

    always_comb begin
        result.status = ST_FORMAT;
        result.fmt    = FMT_GRAY;
        if (sof_bytes[0] != PRECISION_8BIT || sof_count < SOF_CNT_W'(6)) begin
            result.status = ST_FORMAT;
        end else if (sof_bytes[5] == NCOMP_GRAY) begin
            if (sof_count >= SOF_CNT_W'(9) && sof_bytes[6] == COMP_ID_Y
                    && sof_bytes[7] == SAMP_11 && sof_bytes[8] == QTAB_LUMA) begin
                result.status = ST_OK;
                result.fmt    = FMT_GRAY;
            end
        end else if (sof_bytes[5] == NCOMP_YUV) begin
            if (sof_count == SOF_CNT_W'(SOF_DEPTH) && ids_ok) begin
                if (sof_bytes[7] == SAMP_21) begin
                    result.status = ST_OK;
                    result.fmt    = FMT_NV16;
                end else if (sof_bytes[7] == SAMP_22) begin
                    result.status = ST_OK;
                    result.fmt    = FMT_NV12;
                end
            end
        end else begin
            result.status = ST_COMPS;
        end
    end

endmodule

`default_nettype wire

[design/jpeg_sof0_header_parser.sv]
// path: the byte that ends the parse goes through the input and output registers
// throughput: one header byte per cycle; the output register lets a byte in while a
// result waits, and a stalled result stalls the input stage
// reset: aresetn is synchronous and active low; it empties both stages and idles the
// parser until a beat with first_byte set
`default_nettype none

module jpeg_sof0_header_parser
    import jsof_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_header_byte,
    input  wire logic        s_first_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [15:0]      m_image_width,
    output logic [15:0]      m_image_height,
    output logic [1:0]       m_pixel_format,
    output logic             m_format_known,
    output logic [15:0]      m_header_skip
);

    // input stage
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;

    // parser state
    phase_t                 phase_reg, phase_next;
    logic [16:0]            offset_reg, offset_next;
    logic [15:0]            remaining_reg, remaining_next;
    logic [7:0]             marker_reg, marker_next;
    logic [15:0]            seglen_reg, seglen_next;
    sof_bytes_t             sof_reg, sof_next;
    logic [SOF_CNT_W-1:0]   sof_cnt_reg, sof_cnt_next;
    logic [15:0]            height_reg, height_next;
    logic [15:0]            width_reg, width_next;
    pix_fmt_t               fmt_reg, fmt_next;
    logic                   seen_reg, seen_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    status_t     out_status_reg;
    logic [15:0] out_width_reg;
    logic [15:0] out_height_reg;
    pix_fmt_t    out_fmt_reg;
    logic        out_known_reg;
    logic [15:0] out_skip_reg;

    logic        out_free;
    logic        proc;
    logic        active;
    logic [7:0]  hb;
    logic [15:0] len_full;
    logic [15:0] rem_dec;
    logic [17:0] skip_sum;
    logic        sof_last;
    sof_bytes_t  sof_eff;
    logic [SOF_CNT_W-1:0] sof_n;
    sof_eval_t   sof_res;

    logic        res_fire;
    status_t     res_status;
    logic [15:0] res_width;
    logic [15:0] res_height;
    pix_fmt_t    res_fmt;
    logic        res_known;
    logic [15:0] res_skip;

    assign out_free = !out_valid_reg || m_ready;
    assign proc     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign active   = (phase_reg != PH_IDLE) && (phase_reg != PH_DONE);
    assign hb       = in_byte_reg;
    assign len_full = {seglen_reg[15:8], hb};
    assign rem_dec  = remaining_reg - 16'd1;
    assign skip_sum = {1'b0, offset_reg} + {2'b00, len_full} - 18'd1;
    assign sof_last = (sof_cnt_reg == SOF_CNT_W'(SOF_DEPTH - 1)) || (rem_dec == 16'd0);
    assign sof_n    = sof_cnt_reg + SOF_CNT_W'(1);

    // collected payload with the current byte dropped into its slot
    always_comb begin
        for (int i = 0; i < SOF_DEPTH; i++) begin
            sof_eff[i] = (sof_cnt_reg == SOF_CNT_W'(i)) ? hb : sof_reg[i];
        end
    end

    jsof_sof_eval u_sof_eval (
        .sof_bytes (sof_eff),
        .sof_count (sof_n),
        .result    (sof_res)
    );

    // result decode
    always_comb begin
        res_fire   = 1'b0;
        res_status = ST_OK;
        res_width  = 16'd0;
        res_height = 16'd0;
        res_fmt    = FMT_GRAY;
        res_known  = 1'b0;
        res_skip   = 16'd0;
        if (proc) begin
            if (in_first_reg) begin
                if (hb != MARKER_PREFIX) begin
                    res_fire   = 1'b1;
                    res_status = ST_NOSOI;
                end
            end else if (active) begin
                if (offset_reg[16]) begin
                    res_fire   = 1'b1;
                    res_status = ST_LONG;
                end else begin
                    case (phase_reg)
                        PH_SOI: begin
                            if (hb != CODE_SOI) begin
                                res_fire   = 1'b1;
                                res_status = ST_NOSOI;
                            end
                        end
                        PH_MARK: begin
                            if (hb != MARKER_PREFIX) begin
                                res_fire   = 1'b1;
                                res_status = ST_MARKER;
                            end
                        end
                        PH_LENLO: begin
                            if (len_full < 16'd2) begin
                                res_fire   = 1'b1;
                                res_status = ST_MARKER;
                            end else if (marker_reg == CODE_SOS) begin
                                res_fire = 1'b1;
                                if (skip_sum > 18'h0FFFF) begin
                                    res_status = ST_LONG;
                                end else begin
                                    res_status = ST_OK;
                                    res_skip   = skip_sum[15:0];
                                    if (seen_reg) begin
                                        res_width  = width_reg;
                                        res_height = height_reg;
                                        res_fmt    = fmt_reg;
                                        res_known  = 1'b1;
                                    end
                                end
                            end else if (marker_reg == CODE_SOF0 && len_full == 16'd2) begin
                                res_fire   = 1'b1;
                                res_status = ST_FORMAT;
                            end
                        end
                        PH_SOFPAY: begin
                            if (sof_last && sof_res.status != ST_OK) begin
                                res_fire   = 1'b1;
                                res_status = sof_res.status;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (proc) begin
            if (in_first_reg) begin
                phase_next = res_fire ? PH_DONE : PH_SOI;
            end else if (res_fire) begin
                phase_next = PH_DONE;
            end else begin
                case (phase_reg)
                    PH_SOI:   phase_next = PH_MARK;
                    PH_MARK:  phase_next = PH_CODE;
                    PH_CODE:  phase_next = PH_LENHI;
                    PH_LENHI: phase_next = PH_LENLO;
                    PH_LENLO: begin
                        if (marker_reg == CODE_SOF0) begin
                            phase_next = PH_SOFPAY;
                        end else begin
                            phase_next = (len_full == 16'd2) ? PH_MARK : PH_SKIP;
                        end
                    end
                    PH_SOFPAY: begin
                        if (sof_last) begin
                            phase_next = (rem_dec != 16'd0) ? PH_SKIP : PH_MARK;
                        end
                    end
                    PH_SKIP: begin
                        if (rem_dec == 16'd0) begin
                            phase_next = PH_MARK;
                        end
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    // parser datapath
    always_comb begin
        offset_next    = offset_reg;
        remaining_next = remaining_reg;
        marker_next    = marker_reg;
        seglen_next    = seglen_reg;
        sof_next       = sof_reg;
        sof_cnt_next   = sof_cnt_reg;
        height_next    = height_reg;
        width_next     = width_reg;
        fmt_next       = fmt_reg;
        seen_next      = seen_reg;
        if (proc) begin
            if (in_first_reg) begin
                offset_next  = 17'd1;
                seen_next    = 1'b0;
                sof_cnt_next = '0;
            end else if (active && !offset_reg[16]) begin
                offset_next = offset_reg + 17'd1;
                case (phase_reg)
                    PH_CODE:  marker_next = hb;
                    PH_LENHI: seglen_next = {hb, 8'h00};
                    PH_LENLO: begin
                        seglen_next    = len_full;
                        remaining_next = len_full - 16'd2;
                        sof_cnt_next   = '0;
                    end
                    PH_SOFPAY: begin
                        sof_next[sof_cnt_reg] = hb;
                        sof_cnt_next          = sof_n;
                        remaining_next        = rem_dec;
                        if (sof_last && sof_res.status == ST_OK) begin
                            height_next = {sof_eff[1], sof_eff[2]};
                            width_next  = {sof_eff[3], sof_eff[4]};
                            fmt_next    = sof_res.fmt;
                            seen_next   = 1'b1;
                        end
                    end
                    PH_SKIP:  remaining_next = rem_dec;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign out_valid_next = out_free ? (proc && res_fire) : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_header_byte;
            in_first_reg <= s_first_byte;
        end
        offset_reg    <= offset_next;
        remaining_reg <= remaining_next;
        marker_reg    <= marker_next;
        seglen_reg    <= seglen_next;
        sof_reg       <= sof_next;
        sof_cnt_reg   <= sof_cnt_next;
        height_reg    <= height_next;
        width_reg     <= width_next;
        fmt_reg       <= fmt_next;
        seen_reg      <= seen_next;
        if (out_free && proc && res_fire) begin
            out_status_reg <= res_status;
            out_width_reg  <= res_width;
            out_height_reg <= res_height;
            out_fmt_reg    <= res_fmt;
            out_known_reg  <= res_known;
            out_skip_reg   <= res_skip;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_image_width  = out_width_reg;
    assign m_image_height = out_height_reg;
    assign m_pixel_format = out_fmt_reg;
    assign m_format_known = out_known_reg;
    assign m_header_skip  = out_skip_reg;

endmodule

`default_nettype wire

[design/jsof_checker.sv]
`default_nettype none

module jsof_checker
    import jsof_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [15:0] m_image_width,
    input wire logic [15:0] m_image_height,
    input wire logic [1:0]  m_pixel_format,
    input wire logic        m_format_known,
    input wire logic [15:0] m_header_skip
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_header_skip)
            && $stable(m_image_width) && $stable(m_image_height))
        else $error("result beat changed while stalled");

    // error beats carry no image facts
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_image_width == 16'd0
            && m_image_height == 16'd0 && m_header_skip == 16'd0 && !m_format_known)
        else $error("error beat with nonzero fields");

    // no sof0 seen means no size or format
    a_unknown_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_format_known |-> m_image_width == 16'd0
            && m_image_height == 16'd0 && m_pixel_format == FMT_GRAY)
        else $error("image facts without a valid sof0");

    // output empties after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

endmodule

bind jpeg_sof0_header_parser jsof_checker u_jsof_checker (.*);

`default_nettype wire
